>>> hdl/matrix_multiply_unit_assert.svh
// Assertion macros for the matrix multiply unit.
// Each use expects clk and arst_n in the enclosing module.
`ifndef MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_UNIT_ASSERT_SVH

`ifndef SYNTH
`define MMU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("%m: check failed");
`define MMU_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("%m: check failed");
`else
`define MMU_ASSERT(lbl, prop)
`define MMU_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hdl/mmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmu_pkg;

	// item command codes
	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

	// fractional bits of the Q8.8 format
	localparam int unsigned FRAC_BITS = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} mmu_state_t;

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic rd_en;
		logic acc_clear;
		logic out_load;
		logic out_err;
	} mmu_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} mmu_stat_t;

endpackage

`default_nettype wire

>>> hdl/mmu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mmu_datapath
	import mmu_pkg::*;
#(
	parameter int unsigned MAX_DIM    = 16,
	parameter int unsigned ELEM_WIDTH = 16,
	parameter int unsigned ACC_WIDTH  = 40
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mmu_cmd_t                      cmd,
	output mmu_stat_t                          stat,
	input  wire logic [$clog2(MAX_DIM)-1:0]    wr_row,
	input  wire logic [$clog2(MAX_DIM)-1:0]    wr_col,
	input  wire logic signed [ELEM_WIDTH-1:0]  wr_data,
	input  wire logic [$clog2(MAX_DIM)-1:0]    rd_row,
	input  wire logic [$clog2(MAX_DIM)-1:0]    rd_k,
	input  wire logic [$clog2(MAX_DIM)-1:0]    rd_col,
	input  wire logic [$clog2(MAX_DIM)-1:0]    res_row,
	input  wire logic [$clog2(MAX_DIM)-1:0]    res_col,
	input  wire logic                          res_last,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output logic [$clog2(MAX_DIM)-1:0]         m_row,
	output logic [$clog2(MAX_DIM)-1:0]         m_col,
	output logic signed [ELEM_WIDTH-1:0]       m_value,
	output logic                               m_sat,
	output logic                               m_last,
	output logic                               m_status
);

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned QW     = ACC_WIDTH - FRAC_BITS;

	logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

	logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

	logic                           v_s1, v_s2;
	logic signed [ELEM_WIDTH-1:0]   a_s1, b_s1;
	logic signed [2*ELEM_WIDTH-1:0] prod_s2;
	logic signed [ACC_WIDTH-1:0]    acc_q;

	logic signed [QW-1:0]           q;
	logic [QW-ELEM_WIDTH:0]         q_top;
	logic                           sat_c;
	logic signed [ELEM_WIDTH-1:0]   value_c;

	logic out_valid_q;

	assign wr_addr   = ADDR_W'(wr_row) * ADDR_W'(MAX_DIM) + ADDR_W'(wr_col);
	assign rd_addr_a = ADDR_W'(rd_row) * ADDR_W'(MAX_DIM) + ADDR_W'(rd_k);
	assign rd_addr_b = ADDR_W'(rd_k) * ADDR_W'(MAX_DIM) + ADDR_W'(rd_col);

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (cmd.wr_b) begin
			mem_b[wr_addr] <= wr_data;
		end
	end

	// registered read and multiply stages
	always_ff @(posedge clk) begin
		a_s1    <= mem_a[rd_addr_a];
		b_s1    <= mem_b[rd_addr_b];
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_WIDTH'(prod_s2);
		end
	end

	// floor shift, then clip to the element range
	assign q       = acc_q[ACC_WIDTH-1:FRAC_BITS];
	assign q_top   = q[QW-1:ELEM_WIDTH-1];
	assign sat_c   = !((&q_top) || !(|q_top));
	assign value_c = sat_c ? (q[QW-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
	                                  : {1'b0, {(ELEM_WIDTH-1){1'b1}}})
	                       : q[ELEM_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_row <= res_row;
			m_col <= res_col;
			if (cmd.out_err) begin
				m_value  <= '0;
				m_sat    <= 1'b0;
				m_last   <= 1'b1;
				m_status <= 1'b1;
			end else begin
				m_value  <= value_c;
				m_sat    <= sat_c;
				m_last   <= res_last;
				m_status <= 1'b0;
			end
		end
	end

	assign m_tvalid       = out_valid_q;
	assign stat.pipe_busy = v_s1 || v_s2;
	assign stat.out_free  = !out_valid_q || m_tready;

	`include "matrix_multiply_unit_assert.svh"

	// the accumulator must not be cleared under a product still in flight
	`MMU_ASSERT(a_clear_quiet, cmd.acc_clear |-> !v_s1 && !v_s2)
	// a result is never loaded over one that waits
	`MMU_ASSERT(a_load_free, cmd.out_load |-> !out_valid_q || m_tready)

endmodule

`default_nettype wire

>>> hdl/mmu_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module mmu_controller
	import mmu_pkg::*;
#(
	parameter int unsigned MAX_DIM = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [CFG_IDX_W-1:0]               cfg_index,
	input  wire logic [$clog2(MAX_DIM+1)-1:0]       cfg_wdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [1:0]                         command,
	input  wire logic [$clog2(MAX_DIM)-1:0]         row_index,
	input  wire logic [$clog2(MAX_DIM)-1:0]         col_index,
	output mmu_cmd_t                                cmd,
	input  wire mmu_stat_t                          stat,
	output logic [$clog2(MAX_DIM)-1:0]              rd_row,
	output logic [$clog2(MAX_DIM)-1:0]              rd_k,
	output logic [$clog2(MAX_DIM)-1:0]              rd_col,
	output logic [$clog2(MAX_DIM)-1:0]              res_row,
	output logic [$clog2(MAX_DIM)-1:0]              res_col,
	output logic                                    res_last
);

	localparam int unsigned IDX_W = $clog2(MAX_DIM);
	localparam int unsigned CFG_W = $clog2(MAX_DIM + 1);
	localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

	mmu_state_t state_q, state_d;

	logic [CFG_W-1:0] rows_q, inner_q, cols_q;
	logic [CFG_W-1:0] nr, nk, nc;
	logic [IDX_W-1:0] row_q, row_d, k_q, k_d, j_q, j_d;
	logic             accept, k_last, j_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_MAX;
			inner_q <= DIM_MAX;
			cols_q  <= DIM_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:     rows_q  <= cfg_wdata;
				REG_INNER_SIZE: inner_q <= cfg_wdata;
				REG_COLS_B:     cols_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sizes above the store dimension act as the store dimension
	assign nr = (rows_q  > DIM_MAX) ? DIM_MAX : rows_q;
	assign nk = (inner_q > DIM_MAX) ? DIM_MAX : inner_q;
	assign nc = (cols_q  > DIM_MAX) ? DIM_MAX : cols_q;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;
	assign k_last   = (CFG_W'(k_q) + CFG_W'(1)) == nk;
	assign j_last   = (CFG_W'(j_q) + CFG_W'(1)) == nc;

	assign rd_row = row_q;
	assign rd_k   = k_q;
	assign rd_col = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
		end
	end

	always_ff @(posedge clk) begin
		row_q <= row_d;
	end

	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		k_d      = k_q;
		j_d      = j_q;
		cmd      = '0;
		res_row  = row_q;
		res_col  = j_q;
		res_last = j_last;
		unique case (state_q)
			ST_IDLE: begin
				res_row  = row_index;
				res_col  = col_index;
				res_last = 1'b1;
				if (accept) begin
					unique case (command)
						CMD_LOAD_A: begin
							if (CFG_W'(row_index) < nr && CFG_W'(col_index) < nk) begin
								cmd.wr_a = 1'b1;
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_err  = 1'b1;
							end
						end
						CMD_LOAD_B: begin
							if (CFG_W'(row_index) < nk && CFG_W'(col_index) < nc) begin
								cmd.wr_b = 1'b1;
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_err  = 1'b1;
							end
						end
						CMD_COMPUTE: begin
							res_col = '0;
							if (CFG_W'(row_index) >= nr || nc == '0) begin
								cmd.out_load = 1'b1;
								cmd.out_err  = 1'b1;
							end else begin
								cmd.acc_clear = 1'b1;
								row_d   = row_index;
								k_d     = '0;
								j_d     = '0;
								state_d = (nk == '0) ? ST_DRAIN : ST_ISSUE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_ISSUE: begin
				cmd.rd_en = 1'b1;
				k_d       = k_q + IDX_W'(1);
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last product to reach the accumulator
				if (!stat.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.acc_clear = 1'b1;
					k_d           = '0;
					if (j_last) begin
						state_d = ST_IDLE;
					end else begin
						j_d     = j_q + IDX_W'(1);
						state_d = (nk == '0) ? ST_DRAIN : ST_ISSUE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`include "matrix_multiply_unit_assert.svh"

	// every read stays inside the configured sizes
	`MMU_ASSERT(a_read_range, cmd.rd_en |-> (CFG_W'(k_q) < nk) && (CFG_W'(j_q) < nc))
	// the final column of a row hands control back to idle
	`MMU_ASSERT(a_row_end, (state_q == ST_EMIT) && cmd.out_load && j_last |=> state_q == ST_IDLE)
	// no item is taken while a row is in progress
	`MMU_ASSERT_RST(a_no_accept_busy, (state_q != ST_IDLE) |-> !accept)

endmodule

`default_nettype wire

>>> hdl/matrix_multiply_unit.sv
// Load items and ignored items complete in the cycle they are taken; a load or a compute with an
// out-of-range index, or a compute while the column size is zero, emits its error result in the
// cycle after it is taken. A compute item holds the input for a whole row of nc columns, plus
// any output stall: each column streams nk reads through the single memory read, multiply and
// accumulate path, then waits for the pipeline to drain and loads the output register.
// Reset clears the state machine, the pipeline and output valids and sets all three sizes to
// MAX_DIM; the A and B stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_unit
	import mmu_pkg::*;
#(
	parameter int unsigned MAX_DIM    = 16,
	parameter int unsigned ELEM_WIDTH = 16,
	parameter int unsigned ACC_WIDTH  = 40
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
	input  wire logic [$clog2(MAX_DIM+1)-1:0]           cfg_wdata,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// row_index, col_index, element, zero fill
	input  wire logic [((2*$clog2(MAX_DIM)+ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
	// command
	input  wire logic [1:0]                             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// out_row, out_col, product_value, saturated, zero fill
	output logic [((2*$clog2(MAX_DIM)+ELEM_WIDTH+1+7)/8)*8-1:0] m_tdata,
	// status
	output logic                                        m_tuser,
	output logic                                        m_tlast
);

	localparam int unsigned IDX_W = $clog2(MAX_DIM);
	localparam int unsigned OUT_W = ((2 * IDX_W + ELEM_WIDTH + 1 + 7) / 8) * 8;

	mmu_cmd_t  cmd;
	mmu_stat_t stat;

	logic [IDX_W-1:0]             in_row, in_col;
	logic signed [ELEM_WIDTH-1:0] in_elem;
	logic [IDX_W-1:0]             rd_row, rd_k, rd_col, res_row, res_col;
	logic                         res_last;
	logic [IDX_W-1:0]             m_row, m_col;
	logic signed [ELEM_WIDTH-1:0] m_value;
	logic                         m_sat;

	assign in_row  = s_tdata[IDX_W-1:0];
	assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
	assign in_elem = s_tdata[2*IDX_W+ELEM_WIDTH-1:2*IDX_W];

	mmu_controller #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.command   (s_tuser),
		.row_index (in_row),
		.col_index (in_col),
		.cmd       (cmd),
		.stat      (stat),
		.rd_row    (rd_row),
		.rd_k      (rd_k),
		.rd_col    (rd_col),
		.res_row   (res_row),
		.res_col   (res_col),
		.res_last  (res_last)
	);

	mmu_datapath #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.wr_row   (in_row),
		.wr_col   (in_col),
		.wr_data  (in_elem),
		.rd_row   (rd_row),
		.rd_k     (rd_k),
		.rd_col   (rd_col),
		.res_row  (res_row),
		.res_col  (res_col),
		.res_last (res_last),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_row    (m_row),
		.m_col    (m_col),
		.m_value  (m_value),
		.m_sat    (m_sat),
		.m_last   (m_tlast),
		.m_status (m_tuser)
	);

	assign m_tdata = OUT_W'({m_sat, m_value, m_col, m_row});

endmodule

`default_nettype wire

>>> tb/tb_matrix_multiply_unit.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_unit;
	import mmu_pkg::*;

	localparam int DIM           = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_PERCENT  = 28;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;

	typedef struct {
		logic [3:0]  row;
		logic [3:0]  col;
		logic [15:0] value;
		logic        sat;
		logic        last;
		logic        status;
	} product_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [4:0]           cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	// row_index, col_index, element
	logic [23:0]          s_tdata   = '0;
	// command
	logic [1:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// out_row, out_col, product_value, saturated, zero fill
	logic [31:0]          m_tdata;
	// status
	logic                 m_tuser;
	logic                 m_tlast;

	logic signed [15:0] a_store [DIM][DIM];
	logic signed [15:0] b_store [DIM][DIM];
	bit                 a_written [DIM][DIM];
	bit                 b_written [DIM][DIM];
	logic [4:0]         rows_reg  = 5'd16;
	logic [4:0]         inner_reg = 5'd16;
	logic [4:0]         cols_reg  = 5'd16;

	product_result_t pending_products[$];
	int error_count  = 0;
	int items_sent   = 0;
	int stall_cycles = 0;
	int hold_left    = 0;
	bit hold_request = 1'b0;
	bit no_idle      = 1'b0;

	matrix_multiply_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clip_size(logic [4:0] v);
		return (v > DIM) ? DIM : int'(v);
	endfunction

	function automatic logic [15:0] random_element();
		if ($urandom_range(1))
			return 16'($urandom);
		return 16'($urandom_range(1023) - 512);
	endfunction

	function automatic void push_product(logic [3:0] row, logic [3:0] col, logic [15:0] value,
			logic sat, logic last, logic status);
		product_result_t r;
		r.row    = row;
		r.col    = col;
		r.value  = value;
		r.sat    = sat;
		r.last   = last;
		r.status = status;
		pending_products.push_back(r);
	endfunction

	// Update the local copy of the stores and queue the row the item produces.
	function automatic void predict_product(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
			logic signed [15:0] elem);
		int     nr, nk, nc;
		longint sum, q;
		logic   ok;
		nr = clip_size(rows_reg);
		nk = clip_size(inner_reg);
		nc = clip_size(cols_reg);
		case (cmd)
			CMD_LOAD_A, CMD_LOAD_B: begin
				ok = (cmd == CMD_LOAD_A) ? (row < nr && col < nk) : (row < nk && col < nc);
				if (!ok) begin
					push_product(row, col, 16'd0, 1'b0, 1'b1, 1'b1);
				end else if (cmd == CMD_LOAD_A) begin
					a_store[row][col]   = elem;
					a_written[row][col] = 1'b1;
				end else begin
					b_store[row][col]   = elem;
					b_written[row][col] = 1'b1;
				end
			end
			CMD_COMPUTE: begin
				if (row >= nr || nc == 0) begin
					push_product(row, 4'd0, 16'd0, 1'b0, 1'b1, 1'b1);
				end else begin
					for (int j = 0; j < nc; j++) begin
						sum = 0;
						for (int k = 0; k < nk; k++)
							sum += longint'(a_store[row][k]) * longint'(b_store[k][j]);
						// arithmetic shift floors toward minus infinity
						q = sum >>> FRAC_BITS;
						if (q > 32767)
							push_product(row, 4'(j), 16'h7fff, 1'b1, j == nc - 1, 1'b0);
						else if (q < -32768)
							push_product(row, 4'(j), 16'h8000, 1'b1, j == nc - 1, 1'b0);
						else
							push_product(row, 4'(j), q[15:0], 1'b0, j == nc - 1, 1'b0);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] cmd, logic [3:0] row, logic [3:0] col, logic [15:0] elem);
		if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (!no_idle && $urandom_range(99) < IDLE_PERCENT);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {elem, col, row};
		do @(posedge clk); while (!s_tready);
		predict_product(cmd, row, col, elem);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Load any entry the row will read that has not been written yet, then compute it.
	task automatic compute_row(logic [3:0] row);
		int nr, nk, nc;
		nr = clip_size(rows_reg);
		nk = clip_size(inner_reg);
		nc = clip_size(cols_reg);
		if (row < nr) begin
			for (int k = 0; k < nk; k++)
				if (!a_written[row][k])
					send_item(CMD_LOAD_A, row, 4'(k), random_element());
			for (int k = 0; k < nk; k++)
				for (int j = 0; j < nc; j++)
					if (!b_written[k][j])
						send_item(CMD_LOAD_B, 4'(k), 4'(j), random_element());
		end
		send_item(CMD_COMPUTE, row, 4'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [4:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROWS_A:     rows_reg  = value;
			REG_INNER_SIZE: inner_reg = value;
			REG_COLS_B:     cols_reg  = value;
			default: ;
		endcase
	endtask

	task automatic set_sizes(logic [4:0] r, logic [4:0] k, logic [4:0] c);
		wait_drained();
		write_size(REG_ROWS_A, r);
		write_size(REG_INNER_SIZE, k);
		write_size(REG_COLS_B, c);
	endtask

	task automatic test_reset_loads();
		send_item(CMD_LOAD_A, 4'd15, 4'd15, 16'h7fff);
		send_item(CMD_LOAD_A, 4'd0, 4'd0, 16'h8000);
		send_item(CMD_LOAD_B, 4'd15, 4'd15, 16'h8000);
		send_item(CMD_LOAD_B, 4'd0, 4'd0, 16'h7fff);
		send_item(CMD_UNUSED, 4'hf, 4'hf, 16'hffff);
	endtask

	task automatic test_rounding_saturation();
		set_sizes(5'd2, 5'd1, 5'd2);
		send_item(CMD_LOAD_A, 4'd0, 4'd0, 16'h7fff);
		send_item(CMD_LOAD_A, 4'd1, 4'd0, 16'hffff);
		send_item(CMD_LOAD_B, 4'd0, 4'd0, 16'h7fff);
		send_item(CMD_LOAD_B, 4'd0, 4'd1, 16'h8000);
		// clip high and low, then truncate a small negative and a small positive sum
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 16'd0);
		send_item(CMD_COMPUTE, 4'd1, 4'hf, 16'hffff);
		send_item(CMD_LOAD_A, 4'd2, 4'd0, 16'h1234);
		send_item(CMD_LOAD_A, 4'd0, 4'd1, 16'h1234);
		send_item(CMD_LOAD_B, 4'd1, 4'd0, 16'h1234);
		send_item(CMD_LOAD_B, 4'd0, 4'd2, 16'h1234);
		send_item(CMD_COMPUTE, 4'd2, 4'd0, 16'd0);
		send_item(CMD_UNUSED, 4'd0, 4'd0, 16'd0);
	endtask

	task automatic test_size_limits();
		set_sizes(5'd0, 5'd0, 5'd0);
		send_item(CMD_LOAD_A, 4'd0, 4'd0, 16'h0100);
		send_item(CMD_LOAD_B, 4'd0, 4'd0, 16'h0100);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 16'd0);
		// oversized sizes act as the full dimension; an empty inner size sums to zero
		set_sizes(5'd31, 5'd0, 5'd17);
		send_item(CMD_COMPUTE, 4'd15, 4'd0, 16'd0);
		send_item(CMD_LOAD_B, 4'd0, 4'd0, 16'h0100);
		set_sizes(5'd17, 5'd31, 5'd0);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 16'd0);
		send_item(CMD_LOAD_A, 4'd15, 4'd15, 16'h8001);
	endtask

	task automatic test_backpressure();
		set_sizes(5'd4, 5'd3, 5'd4);
		for (int r = 0; r < 4; r++)
			compute_row(4'(r));
		wait_drained();
		// hold the output while rows keep coming so the input stalls
		hold_request = 1'b1;
		repeat (8)
			send_item(CMD_COMPUTE, 4'($urandom_range(3)), 4'($urandom), 16'($urandom));
		wait_drained();
		repeat (3)
			send_item(CMD_COMPUTE, 4'($urandom_range(3)), 4'($urandom), 16'($urandom));
		wait_drained();
	endtask

	task automatic run_phase(logic [4:0] r, logic [4:0] k, logic [4:0] c, int budget, bit calm);
		int target, pick, nr;
		set_sizes(r, k, c);
		no_idle = calm;
		target  = items_sent + budget;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			nr   = clip_size(rows_reg);
			if (pick < 60)
				compute_row((nr > 0) ? 4'($urandom_range(nr - 1)) : 4'd0);
			else if (pick < 82)
				send_item($urandom_range(1) ? CMD_LOAD_A : CMD_LOAD_B, 4'($urandom), 4'($urandom),
					random_element());
			else if (pick < 94)
				compute_row(4'($urandom));
			else
				send_item(CMD_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
		end
		wait_drained();
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		run_phase(5'd3, 5'd3, 5'd3, 30, 1'b0);
		run_phase(5'd16, 5'd16, 5'd1, 30, 1'b1);
		run_phase(5'd16, 5'd1, 5'd16, 30, 1'b0);
		run_phase(5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)),
			30, 1'b0);
		run_phase(5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)), 5'($urandom_range(1, 4)),
			30, 1'b0);
		run_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)),
			30, 1'b0);
		run_phase(5'd1, 5'd1, 5'd1, 20, 1'b0);
	endtask

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		product_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_products.size() == 0) begin
				$error("unexpected result: row %0d col %0d", m_tdata[3:0], m_tdata[7:4]);
				error_count++;
			end else begin
				want = pending_products.pop_front();
				check_field("out_row", want.row, m_tdata[3:0]);
				check_field("out_col", want.col, m_tdata[7:4]);
				check_field("product_value", $signed(want.value), $signed(m_tdata[23:8]));
				check_field("saturated", want.sat, m_tdata[24]);
				check_field("last", want.last, m_tlast);
				check_field("status", want.status, m_tuser);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_loads();
		test_rounding_saturation();
		test_size_limits();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mmu_pkg.sv
hdl/mmu_datapath.sv
hdl/mmu_controller.sv
hdl/matrix_multiply_unit.sv
tb/tb_matrix_multiply_unit.sv
